FILE: hw/rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared constants and controller/datapath types for the Miller-Rabin round.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // Default arithmetic width and the fixed width of the channel fields.
  localparam int unsigned NUMBER_WIDTH_DEF = 63;
  localparam int unsigned FIELD_W          = 63;

  // Operand selection for the modular multiplier.
  typedef enum logic [1:0] {
    MUL_ACC_BASE  = 2'd0,
    MUL_BASE_BASE = 2'd1,
    MUL_Y_Y       = 2'd2
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     split_shift;
    logic     div_step;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     exp_shift;
    logic     t_dec;
    logic     set_verdict;
    logic     verdict;
  } mrr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;
    logic is_two;
    logic div_last;
    logic mul_done;
    logic e_zero;
    logic e_lsb;
    logic e_one;
    logic t_zero;
    logic sq_fail;
    logic acc_one;
  } mrr_status_t;

endpackage

FILE: hw/rtl/mrr_if.sv
// ----------------------------------------------------------------------------
// mrr_if
// Valid/ready channel interfaces for candidates and verdicts.
// ----------------------------------------------------------------------------
interface mrr_in_if import mrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] candidate;
  logic [FIELD_W-1:0] random_word;

  modport source (output valid, output candidate, output random_word, input ready);
  modport sink   (input valid, input candidate, input random_word, output ready);
endinterface

interface mrr_out_if import mrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               probably_prime;
  logic [FIELD_W-1:0] witness_base;

  modport source (output valid, output probably_prime, output witness_base, input ready);
  modport sink   (input valid, input probably_prime, input witness_base, output ready);
endinterface

FILE: hw/rtl/mrr_mulmod.sv
// ----------------------------------------------------------------------------
// mrr_mulmod
// Bit-serial modular multiplier: MSB-first double-and-add, one modular
// addition per cycle, so every intermediate value stays below the modulus.
// ----------------------------------------------------------------------------
module mrr_mulmod import mrr_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] op_x,
  input  logic [NUMBER_WIDTH-1:0] op_y,
  input  logic [NUMBER_WIDTH-1:0] modulus,
  output logic                    done,
  output logic [NUMBER_WIDTH-1:0] result
);

  localparam int unsigned W  = NUMBER_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          add_ph_r, add_ph_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [W-1:0]  x_r, m_r;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  acc_r, acc_nxt;

  logic [W-1:0]  add_b;
  logic [W:0]    sum;
  logic [W+1:0]  diff;
  logic [W-1:0]  sum_mod;

  // One modular addition: doubling in the first phase, adding x in the second.
  always_comb begin
    add_b   = add_ph_r ? x_r : acc_r;
    sum     = {1'b0, acc_r} + {1'b0, add_b};
    diff    = {1'b0, sum} - {2'b00, m_r};
    sum_mod = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
  end

  // Step sequencing over the multiplier bits.
  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    add_ph_nxt = add_ph_r;
    idx_nxt    = idx_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    if (start) begin
      busy_nxt   = 1'b1;
      add_ph_nxt = 1'b0;
      idx_nxt    = CW'(W - 1);
      y_nxt      = op_y;
      acc_nxt    = '0;
    end else if (busy_r) begin
      acc_nxt = sum_mod;
      if (!add_ph_r && y_r[W-1]) begin
        add_ph_nxt = 1'b1;
      end else begin
        add_ph_nxt = 1'b0;
        y_nxt      = y_r << 1;
        idx_nxt    = idx_r - CW'(1);
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    add_ph_r <= add_ph_nxt;
    idx_r    <= idx_nxt;
    y_r      <= y_nxt;
    acc_r    <= acc_nxt;
    if (start) begin
      x_r <= op_x;
      m_r <= modulus;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

FILE: hw/rtl/mrr_datapath.sv
// ----------------------------------------------------------------------------
// mrr_datapath
// Candidate registers, exponent split, base reduction by restoring division,
// modular exponentiation registers and the verdict register.
// ----------------------------------------------------------------------------
module mrr_datapath import mrr_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mrr_cmd_t           cmd,
  output mrr_status_t        st,
  input  logic [FIELD_W-1:0] in_candidate,
  input  logic [FIELD_W-1:0] in_random_word,
  output logic               out_probably_prime,
  output logic [FIELD_W-1:0] out_witness_base
);

  localparam int unsigned W  = NUMBER_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  n_r, nm1_r, r_r, e_r;
  logic [CW-1:0] t_r, div_idx_r;
  logic [W-1:0]  rem_r, a_r, base_r, acc_r;
  mul_sel_t      dest_r;
  logic          prev_ok_r, sq_fail_r, verdict_r;

  logic [W-1:0]  cand_w;
  logic [W:0]    rem_sh;
  logic [W-1:0]  rem_new;
  logic [W-1:0]  mul_x, mul_y, mul_res;
  logic          mul_done;
  logic          trivial;

  assign cand_w = W'(in_candidate);

  // Restoring division step: one dividend bit per cycle while div_step is set.
  always_comb begin
    rem_sh  = {rem_r, r_r[div_idx_r]};
    rem_new = (rem_sh >= {1'b0, nm1_r}) ? W'(rem_sh - {1'b0, nm1_r}) : rem_sh[W-1:0];
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      MUL_ACC_BASE: begin
        mul_x = acc_r;
        mul_y = base_r;
      end
      MUL_BASE_BASE: begin
        mul_x = base_r;
        mul_y = base_r;
      end
      MUL_Y_Y: begin
        mul_x = acc_r;
        mul_y = acc_r;
      end
      default: begin
        mul_x = acc_r;
        mul_y = acc_r;
      end
    endcase
  end

  mrr_mulmod #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .op_x    (mul_x),
    .op_y    (mul_y),
    .modulus (n_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  // Working registers, updated on controller commands.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r       <= cand_w;
      nm1_r     <= cand_w - W'(1);
      e_r       <= cand_w - W'(1);
      t_r       <= '0;
      r_r       <= W'(in_random_word);
      div_idx_r <= CW'(W - 1);
      rem_r     <= '0;
      acc_r     <= W'(1);
      sq_fail_r <= 1'b0;
    end else begin
      if (cmd.split_shift) begin
        e_r <= e_r >> 1;
        t_r <= t_r + CW'(1);
      end
      if (cmd.exp_shift) begin
        e_r <= e_r >> 1;
      end
      if (cmd.t_dec) begin
        t_r <= t_r - CW'(1);
      end
      if (cmd.div_step) begin
        rem_r     <= rem_new;
        div_idx_r <= div_idx_r - CW'(1);
        if (div_idx_r == '0) begin
          a_r    <= rem_new + W'(1);
          base_r <= rem_new + W'(1);
        end
      end
      if (cmd.mul_start) begin
        dest_r    <= cmd.mul_sel;
        prev_ok_r <= (acc_r == W'(1)) || (acc_r == nm1_r);
      end
      // Write back the finished product.
      if (mul_done) begin
        case (dest_r)
          MUL_BASE_BASE: base_r <= mul_res;
          MUL_Y_Y: begin
            acc_r     <= mul_res;
            sq_fail_r <= (mul_res == W'(1)) && !prev_ok_r;
          end
          default: acc_r <= mul_res;
        endcase
      end
    end
    if (cmd.set_verdict) begin
      verdict_r <= cmd.verdict;
    end
  end

  // Status toward the controller.
  assign trivial     = !n_r[0] || (n_r == W'(1));
  assign st.trivial  = trivial;
  assign st.is_two   = (n_r == W'(2));
  assign st.div_last = (div_idx_r == '0);
  assign st.mul_done = mul_done;
  assign st.e_zero   = (e_r == '0);
  assign st.e_lsb    = e_r[0];
  assign st.e_one    = (e_r == W'(1));
  assign st.t_zero   = (t_r == '0);
  assign st.sq_fail  = sq_fail_r;
  assign st.acc_one  = (acc_r == W'(1));

  // Result payload.
  assign out_probably_prime = verdict_r;
  assign out_witness_base   = trivial ? '0 : FIELD_W'(a_r);

endmodule

FILE: hw/rtl/mrr_ctrl.sv
// ----------------------------------------------------------------------------
// mrr_ctrl
// Sequencer for one Miller-Rabin round: trivial check, split of n-1, base
// reduction, square-and-multiply exponentiation, squaring loop and output.
// ----------------------------------------------------------------------------
module mrr_ctrl import mrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mrr_status_t st,
  output mrr_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_SPLIT = 11'b000_0000_0100,
    S_DIV   = 11'b000_0000_1000,
    S_POW   = 11'b000_0001_0000,
    S_MUL_A = 11'b000_0010_0000,
    S_SQB   = 11'b000_0100_0000,
    S_MUL_B = 11'b000_1000_0000,
    S_SQ    = 11'b001_0000_0000,
    S_MUL_Y = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_ACC_BASE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.trivial) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = st.is_two;
          state_nxt       = S_OUT;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (st.e_lsb) begin
          state_nxt = S_DIV;
        end else begin
          cmd.split_shift = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_POW;
        end
      end
      // Square-and-multiply over the odd part of n-1, LSB first.
      S_POW: begin
        if (st.e_zero) begin
          state_nxt = S_SQ;
        end else if (st.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_ACC_BASE;
          state_nxt     = S_MUL_A;
        end else begin
          state_nxt = S_SQB;
        end
      end
      S_MUL_A: begin
        if (st.mul_done) begin
          state_nxt = S_SQB;
        end
      end
      S_SQB: begin
        if (st.e_one) begin
          cmd.exp_shift = 1'b1;
          state_nxt     = S_SQ;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_BASE_BASE;
          state_nxt     = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (st.mul_done) begin
          cmd.exp_shift = 1'b1;
          state_nxt     = S_POW;
        end
      end
      // Repeated squaring with the nontrivial square root check.
      S_SQ: begin
        if (st.sq_fail) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_nxt       = S_OUT;
        end else if (st.t_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = st.acc_one;
          state_nxt       = S_OUT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_Y_Y;
          cmd.t_dec     = 1'b1;
          state_nxt     = S_MUL_Y;
        end
      end
      S_MUL_Y: begin
        if (st.mul_done) begin
          state_nxt = S_SQ;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

FILE: hw/rtl/miller_rabin_round_top.sv
// ----------------------------------------------------------------------------
// miller_rabin_round_top
// One Miller-Rabin round on a candidate below 2^63 per input transfer.
// ----------------------------------------------------------------------------
// Usage: each transfer on in_chan carries a candidate and a random word; one
// transfer on out_chan later returns the verdict and the witness base used.
// Items are processed one at a time: in_chan.ready is high only while the
// block is idle, and goes high again in the cycle after the result transfer.
// Candidates 0, 1, 2 and even values go from the check to the output with base 0.
// Other candidates run the split of n-1 = x * 2^t, the base reduction by
// division and M multiplications in the bit-serial modular multiplier, which
// does one modular addition per cycle while busy; M is at most
// bits(x) - 1 + ones(x) + t.
// Reset (synchronous, active low) returns the sequencer to idle; no item is
// kept. While out_chan.ready is low the result is held stable on out_chan
// and no new candidate is taken.
// ----------------------------------------------------------------------------
module miller_rabin_round_top import mrr_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mrr_in_if.sink           in_chan,
  mrr_out_if.source        out_chan
);

  mrr_cmd_t    cmd;
  mrr_status_t st;

  mrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  mrr_datapath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_candidate       (in_chan.candidate),
    .in_random_word     (in_chan.random_word),
    .out_probably_prime (out_chan.probably_prime),
    .out_witness_base   (out_chan.witness_base)
  );

endmodule

FILE: verif/mrr_verdict_checker.sv
// ----------------------------------------------------------------------------
// mrr_verdict_checker
// Watches the candidate and verdict channels of the Miller-Rabin round,
// computes the expected verdict and witness base for every candidate
// transfer, and compares each verdict transfer against the oldest one.
// ----------------------------------------------------------------------------
module mrr_verdict_checker import mrr_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mrr_in_if           cand_mon,
  mrr_out_if          verdict_mon,
  output int unsigned mismatch_count,
  output int unsigned waiting_count,
  output int unsigned verdicts_checked,
  output int unsigned primes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               prime;
    logic [FIELD_W-1:0] base;
  } verdict_t;

  localparam logic [63:0] NUM_MASK = (NUMBER_WIDTH >= 64) ? ~64'd0
                                                          : ((64'd1 << NUMBER_WIDTH) - 64'd1);

  verdict_t pending_verdicts[$];

  // Exact modular product through a 128-bit intermediate.
  function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod % {64'd0, m};
    return prod[63:0];
  endfunction

  // Square-and-multiply exponentiation, base already reduced below m.
  function automatic logic [63:0] mod_pow(input logic [63:0] base, input logic [63:0] e,
                                          input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] k;
    acc = 64'd1;
    b   = base;
    k   = e;
    while (k != 64'd0) begin
      if (k[0]) acc = mod_mul(acc, b, m);
      b = mod_mul(b, b, m);
      k = k >> 1;
    end
    return acc;
  endfunction

  // One round of the probable-prime test for a candidate and random word.
  function automatic verdict_t round_verdict(input logic [FIELD_W-1:0] cand_raw,
                                             input logic [FIELD_W-1:0] word_raw);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] nm1;
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] y;
    logic [63:0] prev;
    int unsigned t;
    int unsigned i;
    logic        composite;
    logic        stop;
    verdict_t    v;
    n = {1'b0, cand_raw} & NUM_MASK;
    r = {1'b0, word_raw} & NUM_MASK;
    v.prime = 1'b0;
    v.base  = '0;
    // Two is prime; zero, one and even values are composite with no base.
    if (n == 64'd2) begin
      v.prime = 1'b1;
      return v;
    end
    if (n < 64'd2 || !n[0]) return v;

    // Split n-1 into an odd part and a power of two.
    nm1 = n - 64'd1;
    x   = nm1;
    t   = 0;
    while (!x[0]) begin
      x = x >> 1;
      t++;
    end

    a    = (r % nm1) + 64'd1;
    y    = mod_pow(a, x, n);
    prev = y;
    composite = 1'b0;
    stop = 1'b0;
    i    = 0;
    // Repeated squaring, watching for a nontrivial square root of one.
    while (i < t && !stop) begin
      y = mod_mul(y, y, n);
      if (y == 64'd1 && prev != 64'd1 && prev != nm1) begin
        composite = 1'b1;
        stop = 1'b1;
      end else begin
        prev = y;
      end
      i++;
    end
    if (!composite && y != 64'd1) composite = 1'b1;

    v.prime = !composite;
    v.base  = a[FIELD_W-1:0];
    return v;
  endfunction

  // Record expectations on candidate transfers and check verdict transfers.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      mismatch_count   <= 0;
      waiting_count    <= 0;
      verdicts_checked <= 0;
      primes_seen      <= 0;
    end else begin
      if (verdict_mon.valid && verdict_mon.ready) begin
        verdicts_checked <= verdicts_checked + 1;
        if (verdict_mon.probably_prime === 1'b1) primes_seen <= primes_seen + 1;
        if (pending_verdicts.size() == 0) begin
          $display("%0t: verdict transfer with none expected: prime=%b base=%0d",
                   $time, verdict_mon.probably_prime, verdict_mon.witness_base);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict_mon.probably_prime !== want.prime ||
              verdict_mon.witness_base !== want.base) begin
            $display("%0t: verdict mismatch: expected prime=%b base=%0d, got prime=%b base=%0d",
                     $time, want.prime, want.base,
                     verdict_mon.probably_prime, verdict_mon.witness_base);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (cand_mon.valid && cand_mon.ready)
        pending_verdicts.push_back(round_verdict(cand_mon.candidate, cand_mon.random_word));
      waiting_count <= pending_verdicts.size();
    end
  end

endmodule

FILE: verif/miller_rabin_round_top_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_round_top_test
// Drives candidates into the Miller-Rabin round and gives the verdict.
// A directed set covers the trivial candidates, the field extremes, bases of
// one and n-1, and known primes and pseudoprimes; random candidates follow,
// mostly odd values of mixed size, with random idling on both channels, a
// stretch with no idling and one long hold-off on the verdict channel.
// ----------------------------------------------------------------------------
module miller_rabin_round_top_test import mrr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned    RANDOM_ITEMS = 80;
  localparam int unsigned    HOLD_AT      = 35;
  localparam int unsigned    HOLD_CYCLES  = 40000;
  localparam logic [FIELD_W-1:0] MAX63    = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] P63      = 63'd9223372036854775783;
  localparam logic [FIELD_W-1:0] M61      = 63'd2305843009213693951;

  logic        clk;
  logic        rst_n;
  logic        idle_on;
  int unsigned mismatch_count;
  int unsigned waiting_count;
  int unsigned verdicts_checked;
  int unsigned primes_seen;
  int unsigned sent_count;
  int unsigned hold_left;
  logic        hold_done;

  logic [FIELD_W-1:0] known_values[16] = '{
    63'd3, 63'd5, 63'd7, 63'd13, 63'd65537, 63'd2147483647, 63'd4294967291,
    63'd1000000007, 63'd998244353, M61, P63,
    63'd561, 63'd1105, 63'd2047, 63'd3215031751, 63'd25326001
  };

  mrr_in_if  in_chan ();
  mrr_out_if out_chan ();

  miller_rabin_round_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mrr_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cand_mon         (in_chan),
    .verdict_mon      (out_chan),
    .mismatch_count   (mismatch_count),
    .waiting_count    (waiting_count),
    .verdicts_checked (verdicts_checked),
    .primes_seen      (primes_seen)
  );

  // Free-running clock, 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog for a block that hangs.
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [FIELD_W-1:0] rand63();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[FIELD_W-1:0];
  endfunction

  // Offer one candidate, with an optional random gap first, and hold it until
  // the transfer. Returns at a falling edge with valid still high.
  task automatic send(input logic [FIELD_W-1:0] cand, input logic [FIELD_W-1:0] word);
    while (idle_on && $urandom_range(0, 99) < 34) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.candidate   <= cand;
    in_chan.random_word <= word;
    do @(posedge clk); while (!in_chan.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // Verdict side: random stalls, plus one long hold-off that backs up the block.
  initial begin
    out_chan.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && verdicts_checked == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= rst_n && !(idle_on && $urandom_range(0, 99) < 34);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [FIELD_W-1:0] cand;
    logic [FIELD_W-1:0] word;
    int unsigned        sel;
    int unsigned        directed_count;
    int unsigned        total_fail;
    rst_n               = 1'b0;
    idle_on             = 1'b1;
    sent_count          = 0;
    in_chan.valid       = 1'b0;
    in_chan.candidate   = '0;
    in_chan.random_word = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Trivial candidates and field extremes.
    send(63'd0, 63'd0);
    send(63'd1, MAX63);
    send(63'd2, MAX63);
    send(63'd4, 63'h5555_5555_5555_5555);
    send(MAX63 - 63'd1, MAX63);
    send(MAX63, MAX63);
    send(MAX63, 63'h2AAA_AAAA_AAAA_AAAA);
    // Base of one and base of n-1.
    send(63'd3, 63'd0);
    send(63'd3, 63'd1);
    send(63'd5, 63'd3);
    send(63'd65537, 63'd65535);
    send(P63, P63 - 63'd2);
    send(P63, 63'd0);
    // Large primes, composites and strong pseudoprimes.
    send(P63, MAX63);
    send(M61, 63'h2AAA_AAAA_AAAA_AAAA);
    send(63'd4294967297, 63'h5555_5555_5555_5555);
    send(63'd561, 63'd0);
    send(63'd561, 63'd1);
    send(63'd2047, 63'd1);
    send(63'd2047, 63'd2);
    send(63'd25326001, 63'd1);
    directed_count = sent_count;

    // Random candidates, mostly odd so that the full round runs.
    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      idle_on = !(k >= 40 && k < 70);
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        cand = 63'($urandom_range(3, 65535)) | 63'd1;
      end else if (sel < 65) begin
        cand = 63'($urandom()) | 63'd1;
        if (cand == 63'd1) cand = 63'd3;
      end else if (sel < 75) begin
        cand = rand63() | 63'd1;
      end else if (sel < 90) begin
        cand = known_values[$urandom_range(0, 15)];
      end else begin
        case ($urandom_range(0, 3))
          0:       cand = 63'd0;
          1:       cand = 63'd1;
          2:       cand = 63'd2;
          default: cand = rand63() & ~63'd1;
        endcase
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) word = '0;
      else if (sel == 1 && cand >= 63'd3) word = cand - 63'd2;
      else word = rand63();
      send(cand, word);
    end
    in_chan.valid <= 1'b0;
    idle_on = 1'b1;

    // Drain outstanding verdicts, then let the block settle.
    while (waiting_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    total_fail = mismatch_count + waiting_count;
    $display("Sent %0d candidates (%0d directed, %0d random); %0d verdicts checked.",
             sent_count, directed_count, sent_count - directed_count, verdicts_checked);
    $display("%0d verdicts were probably prime; the verdict channel was held off for %0d cycles.",
             primes_seen, HOLD_CYCLES);
    if (total_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
